// File: src/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg
// Types, codes and constants shared by the servo gripper sequencer modules.
// ----------------------------------------------------------------------------
package sgs_pkg;

    localparam int unsigned WIDTH_W   = 12;
    localparam int unsigned DELAY_W   = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // minimum time at the target pulse before declaring a position reached
    localparam logic [TIME_W-1:0] ACTUATION_MS = 32'd500;

    localparam logic [WIDTH_W-1:0] NEUTRAL_RST = 12'd1500;
    localparam logic [WIDTH_W-1:0] GRAB_RST    = 12'd1900;
    localparam logic [WIDTH_W-1:0] RELEASE_RST = 12'd1100;
    localparam logic [DELAY_W-1:0] DELAY_RST   = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEUTRAL_WIDTH = 2'd0,
        REG_GRAB_WIDTH    = 2'd1,
        REG_RELEASE_WIDTH = 2'd2,
        REG_CLOSE_DELAY   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_GRAB    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_INIT    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_RELEASED  = 2'd0,
        PH_RELEASING = 2'd1,
        PH_GRABBING  = 2'd2,
        PH_GRABBED   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        NOTE_NONE          = 3'd0,
        NOTE_GRAB_STARTED  = 3'd1,
        NOTE_GRABBED       = 3'd2,
        NOTE_RELEASE_START = 3'd3,
        NOTE_RELEASED      = 3'd4
    } t_notice;

    typedef struct packed {
        logic [WIDTH_W-1:0] neutral_width;
        logic [WIDTH_W-1:0] grab_width;
        logic [WIDTH_W-1:0] release_width;
        logic [DELAY_W-1:0] close_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic [WIDTH_W-1:0] drive_width;
        t_phase             grip_state;
        t_notice            notice;
    } t_result;

endpackage

// File: src/sgs_cfg.sv
// ----------------------------------------------------------------------------
// sgs_cfg
// Configuration register file: pulse widths and close delay.
// ----------------------------------------------------------------------------
module sgs_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [sgs_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [sgs_pkg::CFG_DAT_W-1:0]    i_wr_data,
    output sgs_pkg::t_cfg                    o_cfg
);

    sgs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_width  <= sgs_pkg::NEUTRAL_RST;
            r_cfg.grab_width     <= sgs_pkg::GRAB_RST;
            r_cfg.release_width  <= sgs_pkg::RELEASE_RST;
            r_cfg.close_delay_ms <= sgs_pkg::DELAY_RST;
        end else if (i_wr_en) begin
            case (sgs_pkg::t_reg_idx'(i_wr_index))
                sgs_pkg::REG_NEUTRAL_WIDTH: begin
                    r_cfg.neutral_width <= i_wr_data[sgs_pkg::WIDTH_W-1:0];
                end
                sgs_pkg::REG_GRAB_WIDTH: begin
                    r_cfg.grab_width <= i_wr_data[sgs_pkg::WIDTH_W-1:0];
                end
                sgs_pkg::REG_RELEASE_WIDTH: begin
                    r_cfg.release_width <= i_wr_data[sgs_pkg::WIDTH_W-1:0];
                end
                sgs_pkg::REG_CLOSE_DELAY: begin
                    r_cfg.close_delay_ms <= i_wr_data[sgs_pkg::DELAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/sgs_step.sv
// ----------------------------------------------------------------------------
// sgs_step
// Gripper state and the next-state logic for one item.
// ----------------------------------------------------------------------------
module sgs_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [1:0]                      i_action,
    input  logic [sgs_pkg::TIME_W-1:0]      i_now_ms,
    input  sgs_pkg::t_cfg                   i_cfg,
    output sgs_pkg::t_result                o_res
);

    sgs_pkg::t_phase                 r_phase;
    logic                            r_pending;
    logic [sgs_pkg::TIME_W-1:0]      r_stamp;
    logic [sgs_pkg::WIDTH_W-1:0]     r_width;

    sgs_pkg::t_phase                 n_phase;
    logic                            n_pending;
    logic [sgs_pkg::TIME_W-1:0]      n_stamp;
    logic [sgs_pkg::WIDTH_W-1:0]     n_width;
    sgs_pkg::t_notice                w_notice;

    logic [sgs_pkg::TIME_W-1:0]      w_elapsed;
    logic                            w_delay_zero;
    logic                            w_delay_done;
    logic                            w_act_done;

    assign w_elapsed    = i_now_ms - r_stamp;
    assign w_delay_zero = (i_cfg.close_delay_ms == '0);
    assign w_delay_done = w_delay_zero ||
        (w_elapsed > {{(sgs_pkg::TIME_W-sgs_pkg::DELAY_W){1'b0}}, i_cfg.close_delay_ms});
    assign w_act_done   = (w_elapsed >= sgs_pkg::ACTUATION_MS);

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_stamp   = r_stamp;
        n_width   = r_width;
        w_notice  = sgs_pkg::NOTE_NONE;
        case (sgs_pkg::t_action'(i_action))
            sgs_pkg::ACT_UPDATE: begin
                if (r_phase == sgs_pkg::PH_GRABBING) begin
                    if (r_pending) begin
                        // fire the delayed close; no completion check this item
                        if (w_delay_done) begin
                            n_width   = i_cfg.grab_width;
                            n_stamp   = i_now_ms;
                            n_pending = 1'b0;
                        end
                    end else if ((r_width == i_cfg.grab_width) && w_act_done) begin
                        n_phase  = sgs_pkg::PH_GRABBED;
                        w_notice = sgs_pkg::NOTE_GRABBED;
                    end
                end else if ((r_phase == sgs_pkg::PH_RELEASING) &&
                             (r_width == i_cfg.release_width) && w_act_done) begin
                    n_phase  = sgs_pkg::PH_RELEASED;
                    w_notice = sgs_pkg::NOTE_RELEASED;
                end
            end
            sgs_pkg::ACT_GRAB: begin
                if ((r_phase != sgs_pkg::PH_GRABBING) && (r_phase != sgs_pkg::PH_GRABBED)) begin
                    n_phase   = sgs_pkg::PH_GRABBING;
                    n_pending = !w_delay_zero;
                    if (w_delay_zero) begin
                        n_width = i_cfg.grab_width;
                    end
                    n_stamp  = i_now_ms;
                    w_notice = sgs_pkg::NOTE_GRAB_STARTED;
                end
            end
            sgs_pkg::ACT_RELEASE: begin
                if ((r_phase != sgs_pkg::PH_RELEASING) &&
                    (r_phase != sgs_pkg::PH_RELEASED)) begin
                    n_phase   = sgs_pkg::PH_RELEASING;
                    n_pending = 1'b0;
                    n_width   = i_cfg.release_width;
                    n_stamp   = i_now_ms;
                    w_notice  = sgs_pkg::NOTE_RELEASE_START;
                end
            end
            sgs_pkg::ACT_INIT: begin
                n_width = i_cfg.neutral_width;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sgs_pkg::PH_RELEASED;
            r_pending <= 1'b0;
            r_stamp   <= '0;
            r_width   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_stamp   <= n_stamp;
            r_width   <= n_width;
        end
    end

    assign o_res.drive_width = n_width;
    assign o_res.grip_state  = n_phase;
    assign o_res.notice      = w_notice;

endmodule

// File: src/servo_gripper_sequencer.sv
// ----------------------------------------------------------------------------
// servo_gripper_sequencer
// Path: input reg, then result reg; the state update is a single register pass.
// Throughput: one item per cycle while the result side is not stalled.
// An item is taken while a result waits, as long as the input register drains.
// Reset (i_rst_n low, synchronous): registers back to their defaults, phase
// released, commanded pulse zero, both pipeline registers empty.
// ----------------------------------------------------------------------------
module servo_gripper_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sgs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sgs_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic [sgs_pkg::TIME_W-1:0]        i_now_ms,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sgs_pkg::WIDTH_W-1:0]       o_drive_width,
    output logic [1:0]                        o_grip_state,
    output logic [2:0]                        o_notice
);

    logic                            r_in_valid;
    logic [1:0]                      r_action;
    logic [sgs_pkg::TIME_W-1:0]      r_now_ms;

    logic                            r_out_valid;
    sgs_pkg::t_result                r_res;

    sgs_pkg::t_cfg                   w_cfg;
    sgs_pkg::t_result                w_res;
    logic                            w_fire;
    logic                            w_in_take;

    assign o_cfg_ready = 1'b1;

    // advance the held item when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_in_take  = i_in_valid && o_in_ready;

    sgs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    sgs_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_action (r_action),
        .i_now_ms (r_now_ms),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_action <= i_action;
            r_now_ms <= i_now_ms;
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_width = r_res.drive_width;
    assign o_grip_state  = r_res.grip_state;
    assign o_notice      = r_res.notice;

endmodule

// File: src/sgs_checker.sv
// ----------------------------------------------------------------------------
// sgs_checker
// Port-level checks for the servo gripper sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sgs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [sgs_pkg::WIDTH_W-1:0]       o_drive_width,
    input logic [1:0]                        o_grip_state,
    input logic [2:0]                        o_notice
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_drive_width) && $stable(o_notice))
        else $error("result changed while stalled");

    a_grabbed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_notice == sgs_pkg::NOTE_GRABBED) |->
            (o_grip_state == sgs_pkg::PH_GRABBED))
        else $error("grabbed notice without grabbed state");

    a_grab_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_notice == sgs_pkg::NOTE_GRAB_STARTED) |->
            (o_grip_state == sgs_pkg::PH_GRABBING))
        else $error("grab start notice without grabbing state");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_notice == sgs_pkg::NOTE_RELEASED) ||
                        (o_notice == sgs_pkg::NOTE_RELEASE_START)) |->
            ((o_grip_state == sgs_pkg::PH_RELEASED) ||
             (o_grip_state == sgs_pkg::PH_RELEASING)))
        else $error("release notice with a grab state");

endmodule

bind servo_gripper_sequencer sgs_checker u_sgs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_drive_width (o_drive_width),
    .o_grip_state  (o_grip_state),
    .o_notice      (o_notice)
);

// File: sim/sgs_checker.sv
// ----------------------------------------------------------------------------
// sgs_scoreboard
// Watches the configuration, input and result channels of the servo gripper
// sequencer. It keeps its own copy of the gripper state and registers, works
// out the result of every accepted input item, and compares each accepted
// result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sgs_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [sgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sgs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_action,
    input  logic [sgs_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [sgs_pkg::WIDTH_W-1:0]   i_drive_width,
    input  logic [1:0]                    i_grip_state,
    input  logic [2:0]                    i_notice,
    output int                            o_fail_count,
    output int                            o_pending
);
    import sgs_pkg::*;

    // gripper state as the block should hold it
    t_cfg               regs;
    t_phase             phase;
    logic               close_waiting;
    logic [TIME_W-1:0]  stamp;
    logic [WIDTH_W-1:0] width_cmd;

    t_result grip_expected_q[$];
    t_result want;
    int      fault_total = 0;
    int      waiting_total = 0;

    assign o_fail_count = fault_total;
    assign o_pending    = waiting_total;

    task automatic flag_error(string msg);
        $display("sgs_scoreboard @%0t: %s", $time, msg);
        fault_total++;
    endtask

    // Advance the gripper by one item and return the result it yields.
    function automatic t_result step_gripper(t_action act, logic [TIME_W-1:0] now);
        t_notice           note;
        logic [TIME_W-1:0] since;
        t_result           res;
        note  = NOTE_NONE;
        since = now - stamp;
        case (act)
            ACT_UPDATE: begin
                if (phase == PH_GRABBING) begin
                    if (close_waiting) begin
                        // fire the delayed close; completion waits for a later update
                        if (regs.close_delay_ms == '0 ||
                            since > 32'(regs.close_delay_ms)) begin
                            width_cmd     = regs.grab_width;
                            stamp         = now;
                            close_waiting = 1'b0;
                        end
                    end else if (width_cmd == regs.grab_width && since >= ACTUATION_MS) begin
                        phase = PH_GRABBED;
                        note  = NOTE_GRABBED;
                    end
                end else if (phase == PH_RELEASING && width_cmd == regs.release_width &&
                             since >= ACTUATION_MS) begin
                    phase = PH_RELEASED;
                    note  = NOTE_RELEASED;
                end
            end
            ACT_GRAB: begin
                if (phase != PH_GRABBING && phase != PH_GRABBED) begin
                    phase         = PH_GRABBING;
                    close_waiting = (regs.close_delay_ms != '0);
                    if (!close_waiting) begin
                        width_cmd = regs.grab_width;
                    end
                    stamp = now;
                    note  = NOTE_GRAB_STARTED;
                end
            end
            ACT_RELEASE: begin
                if (phase != PH_RELEASING && phase != PH_RELEASED) begin
                    phase         = PH_RELEASING;
                    close_waiting = 1'b0;
                    width_cmd     = regs.release_width;
                    stamp         = now;
                    note          = NOTE_RELEASE_START;
                end
            end
            default: begin
                width_cmd = regs.neutral_width;
            end
        endcase
        res.drive_width = width_cmd;
        res.grip_state  = phase;
        res.notice      = note;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.neutral_width  = NEUTRAL_RST;
            regs.grab_width     = GRAB_RST;
            regs.release_width  = RELEASE_RST;
            regs.close_delay_ms = DELAY_RST;
            phase               = PH_RELEASED;
            close_waiting       = 1'b0;
            stamp               = '0;
            width_cmd           = '0;
            grip_expected_q.delete();
            waiting_total <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (grip_expected_q.size() == 0) begin
                    flag_error($sformatf("result with nothing expected: width %0d state %0d notice %0d",
                                         i_drive_width, i_grip_state, i_notice));
                end else begin
                    want = grip_expected_q.pop_front();
                    if (i_drive_width != want.drive_width) begin
                        flag_error($sformatf("drive_width %0d, expected %0d",
                                             i_drive_width, want.drive_width));
                    end
                    if (i_grip_state != want.grip_state) begin
                        flag_error($sformatf("grip_state %0d, expected %0d",
                                             i_grip_state, want.grip_state));
                    end
                    if (i_notice != want.notice) begin
                        flag_error($sformatf("notice %0d, expected %0d", i_notice, want.notice));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_NEUTRAL_WIDTH: regs.neutral_width  = i_cfg_data[WIDTH_W-1:0];
                    REG_GRAB_WIDTH:    regs.grab_width     = i_cfg_data[WIDTH_W-1:0];
                    REG_RELEASE_WIDTH: regs.release_width  = i_cfg_data[WIDTH_W-1:0];
                    REG_CLOSE_DELAY:   regs.close_delay_ms = i_cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                grip_expected_q.push_back(step_gripper(t_action'(i_action), i_now_ms));
            end
            waiting_total <= grip_expected_q.size();
        end
    end

endmodule

// File: sim/tb_servo_gripper_sequencer.sv
// ----------------------------------------------------------------------------
// tb_servo_gripper_sequencer
// Drives grab, release, update and init items with millisecond timestamps
// through the servo gripper sequencer under several register settings, with
// random idles on both channels, and leaves prediction and checking to
// sgs_scoreboard.
// ----------------------------------------------------------------------------
module tb_servo_gripper_sequencer;
    import sgs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 120;
    localparam int HOLD_CYCLES = 300;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_NEUTRAL_WIDTH;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_action    = ACT_UPDATE;
    logic [TIME_W-1:0]    i_now_ms    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [WIDTH_W-1:0]   o_drive_width;
    logic [1:0]           o_grip_state;
    logic [2:0]           o_notice;

    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                items_sent  = 0;
    int                hold_kick   = 0;
    int                hold_seen   = 0;
    int                hold_left   = 0;
    bit                calm        = 1'b0;
    logic [DELAY_W-1:0] cur_delay  = DELAY_RST;
    logic [TIME_W-1:0]  clock_ms   = '0;

    servo_gripper_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_drive_width (o_drive_width),
        .o_grip_state  (o_grip_state),
        .o_notice      (o_notice)
    );

    sgs_scoreboard u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_now_ms      (i_now_ms),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_drive_width (o_drive_width),
        .i_grip_state  (o_grip_state),
        .i_notice      (o_notice),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_servo_gripper_sequencer: errors");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_kick != hold_seen) begin
            hold_seen   <= hold_kick;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 32);
        end
    end

    // Step the millisecond clock, favoring the actuation and close-delay edges.
    function automatic logic [TIME_W-1:0] advance_ms();
        int unsigned       pick;
        logic [TIME_W-1:0] step;
        pick = $urandom_range(99);
        if (pick < 10) begin
            step = '0;
        end else if (pick < 22) begin
            step = $urandom_range(502, 498);
        end else if (pick < 32) begin
            step = 32'(cur_delay) + 32'($urandom_range(2)) - 32'd1;
        end else if (pick < 85) begin
            step = $urandom_range(300);
        end else if (pick < 96) begin
            step = $urandom_range(70000);
        end else begin
            step = $urandom();
        end
        clock_ms = clock_ms + step;
        return clock_ms;
    endfunction

    // Hold valid across back-to-back items; drop it only for an idle gap.
    task automatic send_item(t_action act, logic [TIME_W-1:0] t);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 32) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_now_ms   <= t;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_regs(logic [CFG_DAT_W-1:0] neutral, logic [CFG_DAT_W-1:0] grab,
                            logic [CFG_DAT_W-1:0] release_w, logic [CFG_DAT_W-1:0] delay);
        logic [CFG_DAT_W-1:0] vals [4];
        vals[0] = neutral;
        vals[1] = grab;
        vals[2] = release_w;
        vals[3] = delay;
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_reg_idx'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_delay = delay;
    endtask

    task automatic mix_actions(int n);
        int stop_at;
        int pick;
        int runs;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            runs = $urandom_range(6, 1);
            if (pick < 40) begin
                send_item(ACT_GRAB, advance_ms());
                repeat (runs) send_item(ACT_UPDATE, advance_ms());
            end else if (pick < 80) begin
                send_item(ACT_RELEASE, advance_ms());
                repeat (runs) send_item(ACT_UPDATE, advance_ms());
            end else begin
                repeat (runs) send_item(t_action'($urandom_range(3)), advance_ms());
            end
        end
    endtask

    localparam logic [TIME_W-1:0] T0 = 32'hFFFF_FF00;
    localparam logic [TIME_W-1:0] T2 = 32'h0000_1000;

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: commands before any pulse, repeats, wrap of the clock
        send_item(ACT_UPDATE,  T0);
        send_item(ACT_RELEASE, T0);
        send_item(ACT_GRAB,    T0);
        send_item(ACT_GRAB,    T0 + 32'd10);
        send_item(ACT_UPDATE,  T0 + 32'd499);
        send_item(ACT_UPDATE,  T0 + 32'd500);
        send_item(ACT_GRAB,    T0 + 32'd600);
        send_item(ACT_INIT,    T0 + 32'd601);
        send_item(ACT_RELEASE, T0 + 32'd700);
        send_item(ACT_RELEASE, T0 + 32'd701);
        send_item(ACT_INIT,    T0 + 32'd702);
        send_item(ACT_UPDATE,  T0 + 32'd1400);
        send_item(ACT_UPDATE,  32'hFFFF_FFFF);
        wait_drained();

        // delayed close: fires only once the delay is strictly exceeded
        set_regs(16'd1500, 16'd1900, 16'd1100, 16'd100);
        send_item(ACT_GRAB,    T2);
        send_item(ACT_UPDATE,  T2 + 32'd100);
        send_item(ACT_UPDATE,  T2 + 32'd101);
        send_item(ACT_UPDATE,  T2 + 32'd600);
        send_item(ACT_UPDATE,  T2 + 32'd601);
        send_item(ACT_RELEASE, T2 + 32'd700);
        send_item(ACT_UPDATE,  T2 + 32'd1200);
        send_item(ACT_UPDATE,  32'd0);
        send_item(ACT_GRAB,    T2 + 32'd2000);
        send_item(ACT_INIT,    T2 + 32'd2001);
        send_item(ACT_RELEASE, T2 + 32'd2002);
        // leave a close pending so the next setting (no delay) fires it
        send_item(ACT_GRAB,    T2 + 32'd2100);
        wait_drained();
        clock_ms = T2 + 32'd3000;

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_regs(16'd0, 16'd4095, 16'd0, 16'd0);
                1: set_regs(16'd4095, 16'd0, 16'd4095, 16'd65535);
                2: set_regs(16'd2000, 16'd2000, 16'd2000, 16'd1);
                3: set_regs(16'($urandom_range(4095)), 16'($urandom_range(4095)),
                            16'($urandom_range(4095)), 16'($urandom_range(800, 1)));
                4: set_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                            16'($urandom_range(65535)), 16'd0);
                5: set_regs(16'($urandom_range(4095)), 16'($urandom_range(4095)),
                            16'($urandom_range(4095)), 16'($urandom_range(65535)));
                6: set_regs(16'd1500, 16'd1900, 16'd1100, 16'd0);
                default: set_regs(16'($urandom_range(4095)), 16'($urandom_range(4095)),
                                  16'($urandom_range(4095)), 16'($urandom_range(40, 1)));
            endcase
            calm = (p == 2);
            send_item(ACT_UPDATE, advance_ms());
            mix_actions(PHASE_ITEMS);
            // stall the result side long enough to back up the input
            if (p == 3) hold_kick++;
            if (p == 6) wait_drained();
            mix_actions(PHASE_ITEMS);
            wait_drained();
        end
        calm = 1'b0;

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_servo_gripper_sequencer: clean");
        end else begin
            $display("tb_servo_gripper_sequencer: errors");
        end
        $finish;
    end

endmodule
